/* rtl/http_chunked_body_decoder_macros.svh */
// Assertion macros shared by the chunked body decoder
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// Check that a condition implies another in the same cycle
`define CHBD_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("chbd: same-cycle check failed");

// Check that a condition implies another in the next cycle
`define CHBD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("chbd: next-cycle check failed");

`endif

/* rtl/chbd_pkg.sv */
package chbd_pkg;

  // Final status codes as seen on the result channel
  typedef enum logic [1:0] {
    StRunning   = 2'd0,
    StComplete  = 2'd1,
    StMalformed = 2'd2,
    StTooLarge  = 2'd3
  } status_e;

  // Parse phase of the back end
  typedef enum logic {
    PhSize = 1'b0,
    PhData = 1'b1
  } phase_e;

  // Configuration register indexes
  localparam logic CfgBodyLimit  = 1'b0;
  localparam logic CfgLimitCheck = 1'b1;

  localparam int unsigned LimitW  = 48;
  localparam int unsigned AccumW  = 56;
  localparam int unsigned TotalW  = 57;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  // Classified input item passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       hex_ok;
    logic [3:0] nibble;
    logic       is_cr;
    logic       is_lf;
  } item_t;

  // Back-end state visible to the top level
  typedef struct packed {
    status_e final_status;
    phase_e  phase;
  } back_stat_t;

endpackage

/* rtl/chbd_front.sv */
module chbd_front import chbd_pkg::*; (
  input  logic       in_valid_i,
  input  logic [7:0] data_byte_i,
  input  logic       q_full_i,
  output logic       in_stall_o,
  output logic       push_o,
  output item_t      item_o
);

  // Classify the raw byte
  always_comb begin
    item_o        = '0;
    item_o.data   = data_byte_i;
    item_o.is_cr  = (data_byte_i == 8'h0D);
    item_o.is_lf  = (data_byte_i == 8'h0A);
    if (data_byte_i inside {[8'h30:8'h39]}) begin
      item_o.hex_ok = 1'b1;
      item_o.nibble = data_byte_i[3:0];
    end else if (data_byte_i inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      item_o.hex_ok = 1'b1;
      item_o.nibble = data_byte_i[3:0] + 4'd9;
    end
  end

  // Hold off the sender while the queue is full
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

/* rtl/chbd_queue.sv */
module chbd_queue import chbd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  valid_o,
  output item_t item_o
);

  item_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

endmodule

/* rtl/chbd_back.sv */
module chbd_back import chbd_pkg::*; #(
  parameter int unsigned MAX_LINE_BYTES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [LimitW-1:0] cfg_data_i,
  input  logic              q_valid_i,
  input  item_t             q_item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        payload_byte_o,
  output logic              payload_valid_o,
  output logic [1:0]        status_o,
  output back_stat_t        stat_o
);

  localparam int unsigned LbW = $clog2(MAX_LINE_BYTES + 1);

  logic [LimitW-1:0] body_limit_q;
  logic              limit_check_q;

  phase_e            phase_q, phase_d;
  logic [AccumW-1:0] accum_q, accum_d;
  logic [LbW-1:0]    line_bytes_q, line_bytes_d;
  logic              cr_pend_q, cr_pend_d;
  logic [AccumW-1:0] remain_q, remain_d;
  logic [TotalW-1:0] total_q, total_d;
  status_e           status_q, status_d;

  logic              out_valid_q, out_valid_d;
  logic [7:0]        pay_q, pay_d;
  logic              pay_valid_q, pay_valid_d;

  logic [TotalW:0]   sum_wide;
  logic [TotalW-1:0] sum_sat;
  logic [LbW-1:0]    lb_inc;
  logic [AccumW-1:0] remain_dec;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_limit_q  <= '0;
      limit_check_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgBodyLimit:  body_limit_q  <= cfg_data_i;
        CfgLimitCheck: limit_check_q <= cfg_data_i[0];
        default:       body_limit_q  <= body_limit_q;
      endcase
    end
  end

  // Take the next item when the result register is free
  assign pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  // Saturating running total with the current size
  assign sum_wide   = {1'b0, total_q} + {{(TotalW + 1 - AccumW){1'b0}}, accum_q};
  assign sum_sat    = sum_wide[TotalW] ? '1 : sum_wide[TotalW-1:0];
  assign lb_inc     = line_bytes_q + 1'b1;
  assign remain_dec = remain_q - 1'b1;

  // Next parse state
  always_comb begin
    phase_d      = phase_q;
    accum_d      = accum_q;
    line_bytes_d = line_bytes_q;
    cr_pend_d    = cr_pend_q;
    remain_d     = remain_q;
    total_d      = total_q;
    status_d     = status_q;
    if (pop_o && status_q == StRunning) begin
      case (phase_q)
        PhData: begin
          remain_d = remain_dec;
          if (remain_dec == '0) begin
            phase_d      = PhSize;
            accum_d      = '0;
            line_bytes_d = '0;
            cr_pend_d    = 1'b0;
          end
        end
        PhSize: begin
          if (cr_pend_q) begin
            if (!q_item_i.is_lf) begin
              status_d = StMalformed;
            end else begin
              accum_d      = '0;
              line_bytes_d = '0;
              cr_pend_d    = 1'b0;
              // Skip an empty line, else close a size line
              if (line_bytes_q > LbW'(1)) begin
                total_d = sum_sat;
                if (limit_check_q && (sum_sat > {{(TotalW - LimitW){1'b0}}, body_limit_q})) begin
                  status_d = StTooLarge;
                end else if (accum_q == '0) begin
                  status_d = StComplete;
                end else begin
                  remain_d = accum_q;
                  phase_d  = PhData;
                end
              end
            end
          end else begin
            line_bytes_d = lb_inc;
            if (q_item_i.is_cr) begin
              cr_pend_d = 1'b1;
            end else if (q_item_i.hex_ok) begin
              accum_d = (accum_q[AccumW-1 -: 4] != 4'd0) ? '1 :
                        {accum_q[AccumW-5:0], q_item_i.nibble};
            end
            if (!q_item_i.is_cr && !q_item_i.hex_ok) begin
              status_d = StMalformed;
            end else if (lb_inc >= LbW'(MAX_LINE_BYTES)) begin
              status_d = StMalformed;
            end
          end
        end
        default: phase_d = PhSize;
      endcase
    end
  end

  // Result register contents
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    pay_d       = pay_q;
    pay_valid_d = pay_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
      pay_valid_d = (status_q == StRunning) && (phase_q == PhData);
      pay_d       = pay_valid_d ? q_item_i.data : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhSize;
      accum_q      <= '0;
      line_bytes_q <= '0;
      cr_pend_q    <= 1'b0;
      remain_q     <= '0;
      total_q      <= '0;
      status_q     <= StRunning;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      accum_q      <= accum_d;
      line_bytes_q <= line_bytes_d;
      cr_pend_q    <= cr_pend_d;
      remain_q     <= remain_d;
      total_q      <= total_d;
      status_q     <= status_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pay_q       <= pay_d;
      pay_valid_q <= pay_valid_d;
    end
  end

  logic [1:0] status_out_q;
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_out_q <= status_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_byte_o  = pay_q;
  assign payload_valid_o = pay_valid_q;
  assign status_o        = status_out_q;
  assign stat_o          = '{final_status: status_q, phase: phase_q};

endmodule

/* rtl/http_chunked_body_decoder.sv */
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   data_byte_i
// out      output     out_valid_o / out_stall_i payload_byte_o, payload_valid_o, status_o
// cfg      input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// One byte per cycle sustained while out_stall_i is low. A byte's result passes
// through the queue entry, then the parse stage into the result register.
// The size-line parse, total add and limit compare are combinational in the back end.
// Reset is asynchronous, active low; it clears parse state and sets limit_check.
// The two-entry queue takes up to two items while the result side stalls; once it
// is full the input stalls until the back end pops an item.
`include "http_chunked_body_decoder_macros.svh"

module http_chunked_body_decoder import chbd_pkg::*; #(
  parameter int unsigned MAX_LINE_BYTES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [LimitW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        payload_byte_o,
  output logic              payload_valid_o,
  output logic [1:0]        status_o
);

  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_valid;
  item_t      push_item;
  item_t      head_item;
  back_stat_t stat;

  chbd_front u_front (
    .in_valid_i  (in_valid_i),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .item_o      (push_item)
  );

  chbd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  chbd_back #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .q_valid_i       (q_valid),
    .q_item_i        (head_item),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .payload_byte_o  (payload_byte_o),
    .payload_valid_o (payload_valid_o),
    .status_o        (status_o),
    .stat_o          (stat)
  );

  // A final status never changes once reached
  `CHBD_ASSERT_NEXT(a_status_sticky, stat.final_status != StRunning, $stable(stat.final_status))
  // Payload only goes out while the body is still running
  `CHBD_ASSERT_NOW(a_payload_running, out_valid_o && payload_valid_o, status_o == 2'(StRunning))
  // A non-payload result carries a zero byte
  `CHBD_ASSERT_NOW(a_idle_byte_zero, out_valid_o && !payload_valid_o, payload_byte_o == 8'd0)
  // The back end never pops an empty queue
  `CHBD_ASSERT_NOW(a_no_empty_pop, pop, q_valid)

endmodule
